[rtl/core/stc_pkg.sv]
// stc_pkg: shared types, constants and the pixel distance function
// for the sad template classifier; no dependencies
package stc_pkg;

	localparam int MAX_TEMPLATES_DEF = 16;
	localparam int MAX_DIM_DEF       = 32;
	localparam int CHANNELS_DEF      = 3;

	localparam logic [19:0] SCORE_MAX = 20'hFFFFF;
	localparam logic [2:0]  SHIFT_MAX = 3'd4;

	localparam logic [2:0] REG_TW  = 3'd0;
	localparam logic [2:0] REG_TH  = 3'd1;
	localparam logic [2:0] REG_PW  = 3'd2;
	localparam logic [2:0] REG_PH  = 3'd3;
	localparam logic [2:0] REG_CNT = 3'd4;
	localparam logic [2:0] REG_SDX = 3'd5;
	localparam logic [2:0] REG_SDY = 3'd6;

	localparam logic [5:0] TW_RST  = 6'd20;
	localparam logic [5:0] TH_RST  = 6'd20;
	localparam logic [5:0] PW_RST  = 6'd19;
	localparam logic [5:0] PH_RST  = 6'd19;
	localparam logic [4:0] CNT_RST = 5'd15;
	localparam logic [2:0] SDX_RST = 3'd2;
	localparam logic [2:0] SDY_RST = 3'd3;

	localparam logic OP_TEMPLATE = 1'b0;
	localparam logic OP_PATCH    = 1'b1;

	typedef struct packed {
		logic       op;
		logic [3:0] slot;
		logic [4:0] col;
		logic [4:0] row;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last_pixel;
	} in_t;

	typedef struct packed {
		logic [3:0]  best_template;
		logic [19:0] best_score;
		logic        size_error;
	} out_t;

	// clamped geometry
	typedef struct packed {
		logic [7:0] tw;
		logic [7:0] th;
		logic [7:0] pw;
		logic [7:0] ph;
		logic [6:0] cnt;
		logic [2:0] sdx;
		logic [2:0] sdy;
	} geom_t;

	// per-element pipeline control
	typedef struct packed {
		logic valid;
		logic in_tpl;
		logic start;
		logic last;
		logic first;
	} ctl_t;

	function automatic logic [9:0] pix_sad(input logic [23:0] a, input logic [23:0] b,
		input int channels);
		logic [9:0] sum;
		logic [7:0] x;
		logic [7:0] y;
		sum = '0;
		for (int c = 0; c < 3; c++) begin
			x = a[8*c +: 8];
			y = b[8*c +: 8];
			if (c < channels) begin
				sum = sum + ((x > y) ? 10'(x - y) : 10'(y - x));
			end
		end
		return sum;
	endfunction

endpackage

[rtl/core/stc_lane.sv]
// stc_lane: one template memory with its distance, shift sum and minimum
// depends on stc_pkg
module stc_lane #(
	parameter int MAX_DIM  = stc_pkg::MAX_DIM_DEF,
	parameter int CHANNELS = stc_pkg::CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [2*$clog2(MAX_DIM)-1:0] wr_addr,
	input  logic [23:0]                  wr_data,
	input  logic [2*$clog2(MAX_DIM)-1:0] rd_addr,
	input  logic [23:0]                  pat_s1,
	input  stc_pkg::ctl_t                ctl_s2,
	output logic [19:0]                  best
);
	localparam int AW = $clog2(MAX_DIM);
	localparam int DEPTH = 1 << (2 * AW);

	logic [23:0] mem [DEPTH];
	logic [23:0] tpl_s1;
	logic [9:0]  sad_s2;
	logic [19:0] sum_q;
	logic [19:0] best_q;
	logic [20:0] nsum_w;
	logic [19:0] nsum;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		tpl_s1 <= mem[rd_addr];
		sad_s2 <= stc_pkg::pix_sad(tpl_s1, pat_s1, CHANNELS);
	end

	always_comb begin
		nsum_w = 21'(ctl_s2.start ? 20'd0 : sum_q) + 21'(ctl_s2.in_tpl ? sad_s2 : 10'd0);
		nsum = (nsum_w > 21'(stc_pkg::SCORE_MAX)) ? stc_pkg::SCORE_MAX : nsum_w[19:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			best_q <= '0;
		end else if (ctl_s2.valid) begin
			sum_q <= nsum;
			if (ctl_s2.last && (ctl_s2.first || nsum < best_q)) begin
				best_q <= nsum;
			end
		end
	end

	assign best = best_q;

endmodule

[rtl/core/stc_ctrl.sv]
// stc_ctrl: sequencer over shifts and patch pixels, patch memory and
// the merge of lane minima; depends on stc_pkg
module stc_ctrl #(
	parameter int MAX_TEMPLATES = stc_pkg::MAX_TEMPLATES_DEF,
	parameter int MAX_DIM       = stc_pkg::MAX_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  stc_pkg::in_t                        item,
	input  stc_pkg::geom_t                      geom,
	input  logic [MAX_TEMPLATES-1:0][19:0]      lane_best,
	output logic [2*$clog2(MAX_DIM)-1:0]        tpl_addr,
	output logic [23:0]                         pat_s1,
	output stc_pkg::ctl_t                       ctl_s2,
	output logic                                busy,
	output logic                                done,
	output stc_pkg::out_t                       result
);
	localparam int AW  = $clog2(MAX_DIM);
	localparam int TIW = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_MERGE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [23:0] pmem [1 << (2 * AW)];
	logic [2:0]  state_q;
	logic [AW-1:0] sx_q, sy_q;
	logic signed [3:0] dx_q, dy_q;
	logic [TIW-1:0] t_q;
	logic [19:0] score_q;
	logic [TIW-1:0] bi_q;
	logic        err_q;
	stc_pkg::ctl_t ctl_s0, ctl_s1;

	logic signed [3:0] sdx, sdy;
	logic [7:0] offx, offy;
	logic signed [9:0] bx, by;
	logic sx_last, sy_last, err_now, in_range;

	always_comb begin
		sdx = $signed({1'b0, geom.sdx});
		sdy = $signed({1'b0, geom.sdy});
		offx = (geom.tw - geom.pw) >> 1;
		offy = (geom.th - geom.ph) >> 1;
		bx = $signed(10'(sx_q)) + $signed({2'b0, offx}) + 10'(dx_q);
		by = $signed(10'(sy_q)) + $signed({2'b0, offy}) + 10'(dy_q);
		sx_last = (8'(sx_q) == geom.pw - 8'd1);
		sy_last = (8'(sy_q) == geom.ph - 8'd1);
		err_now = (geom.pw > geom.tw) || (geom.ph > geom.th);
		in_range = (int'(item.col) < MAX_DIM) && (int'(item.row) < MAX_DIM);
		ctl_s0.valid  = (state_q == ST_SCAN);
		ctl_s0.in_tpl = !bx[9] && !by[9] && (bx < $signed({2'b0, geom.tw}))
			&& (by < $signed({2'b0, geom.th}));
		ctl_s0.start  = (sx_q == '0) && (sy_q == '0);
		ctl_s0.last   = sx_last && sy_last;
		ctl_s0.first  = (dx_q == -sdx) && (dy_q == -sdy);
		tpl_addr = {by[AW-1:0], bx[AW-1:0]};
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == stc_pkg::OP_PATCH && in_range) begin
			pmem[{AW'(item.row), AW'(item.col)}] <= {item.red, item.green, item.blue};
		end
		pat_s1 <= pmem[{sy_q, sx_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctl_s1  <= '0;
			ctl_s2  <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			t_q     <= '0;
			score_q <= '0;
			bi_q    <= '0;
			err_q   <= 1'b0;
		end else begin
			ctl_s1 <= ctl_s0;
			ctl_s2 <= ctl_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.op == stc_pkg::OP_PATCH && item.last_pixel) begin
						bi_q <= '0;
						if (err_now) begin
							score_q <= stc_pkg::SCORE_MAX;
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							err_q   <= 1'b0;
							sx_q    <= '0;
							sy_q    <= '0;
							dx_q    <= -sdx;
							dy_q    <= -sdy;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (sx_last) begin
						sx_q <= '0;
						if (sy_last) begin
							sy_q <= '0;
							if (dx_q == sdx) begin
								dx_q <= -sdx;
								if (dy_q == sdy) begin
									state_q <= ST_DRAIN;
								end else begin
									dy_q <= dy_q + 4'sd1;
								end
							end else begin
								dx_q <= dx_q + 4'sd1;
							end
						end else begin
							sy_q <= sy_q + AW'(1);
						end
					end else begin
						sx_q <= sx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!ctl_s1.valid && !ctl_s2.valid) begin
						t_q     <= '0;
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (t_q == '0 || lane_best[t_q] < score_q) begin
						score_q <= lane_best[t_q];
						bi_q    <= t_q;
					end
					if (7'(t_q) == geom.cnt - 7'd1) begin
						state_q <= ST_DONE;
					end else begin
						t_q <= t_q + TIW'(1);
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign result.best_template = 4'(bi_q);
	assign result.best_score    = score_q;
	assign result.size_error    = err_q;

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> state_q == ST_IDLE)
		else $error("result strobe longer than one cycle");
	a_merge_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MERGE |-> !ctl_s2.valid && !ctl_s1.valid)
		else $error("merge started with elements in flight");
	a_err_score: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.size_error |-> result.best_score == stc_pkg::SCORE_MAX
			&& result.best_template == 4'd0)
		else $error("size error result malformed");

endmodule

[rtl/core/sad_template_classifier.sv]
// sad_template_classifier: top level, configuration registers, template lanes
// and sequencer; depends on stc_pkg, stc_lane, stc_ctrl
//
// channel   signals                          transaction
// item      start, busy, in                  start & !busy
// result    done, result                     done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid & cfg_ready
//
// a last patch pixel starts matching: the shared pixel scan over every shift and
// patch pixel, all lanes in parallel, then the drain of the lane pipelines and the
// merge over template_count lane minima, and the result cycle
// a size error gives the result in the cycle right after the load
// busy is high from the last patch pixel until after the result cycle
// reset clears control and loads the configuration reset values; memories are not cleared
module sad_template_classifier #(
	parameter int MAX_TEMPLATES = stc_pkg::MAX_TEMPLATES_DEF,
	parameter int MAX_DIM       = stc_pkg::MAX_DIM_DEF,
	parameter int CHANNELS      = stc_pkg::CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  stc_pkg::in_t  in,
	output logic          done,
	output stc_pkg::out_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [5:0]    cfg_data
);
	localparam int AW = $clog2(MAX_DIM);
	localparam logic [7:0] MD8 = 8'(MAX_DIM);
	localparam logic [6:0] MT7 = 7'(MAX_TEMPLATES);

	logic [5:0] tw_q, th_q, pw_q, ph_q;
	logic [4:0] cnt_q;
	logic [2:0] sdx_q, sdy_q;
	stc_pkg::geom_t geom;
	logic accept, in_range;
	logic [2*AW-1:0] tpl_addr;
	logic [23:0] pat_s1;
	stc_pkg::ctl_t ctl_s2;
	logic [MAX_TEMPLATES-1:0][19:0] lane_best;

	function automatic logic [7:0] clamp_dim(input logic [5:0] v, input logic [7:0] hi);
		logic [7:0] w;
		w = {2'b0, v};
		if (w == 8'd0) begin
			return 8'd1;
		end
		return (w > hi) ? hi : w;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q  <= stc_pkg::TW_RST;
			th_q  <= stc_pkg::TH_RST;
			pw_q  <= stc_pkg::PW_RST;
			ph_q  <= stc_pkg::PH_RST;
			cnt_q <= stc_pkg::CNT_RST;
			sdx_q <= stc_pkg::SDX_RST;
			sdy_q <= stc_pkg::SDY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				stc_pkg::REG_TW:  tw_q  <= cfg_data;
				stc_pkg::REG_TH:  th_q  <= cfg_data;
				stc_pkg::REG_PW:  pw_q  <= cfg_data;
				stc_pkg::REG_PH:  ph_q  <= cfg_data;
				stc_pkg::REG_CNT: cnt_q <= cfg_data[4:0];
				stc_pkg::REG_SDX: sdx_q <= cfg_data[2:0];
				stc_pkg::REG_SDY: sdy_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		geom.tw  = clamp_dim(tw_q, MD8);
		geom.th  = clamp_dim(th_q, MD8);
		geom.pw  = clamp_dim(pw_q, MD8);
		geom.ph  = clamp_dim(ph_q, MD8);
		geom.cnt = (cnt_q == 5'd0) ? 7'd1 : (({2'b0, cnt_q} > MT7) ? MT7 : {2'b0, cnt_q});
		geom.sdx = (sdx_q > stc_pkg::SHIFT_MAX) ? stc_pkg::SHIFT_MAX : sdx_q;
		geom.sdy = (sdy_q > stc_pkg::SHIFT_MAX) ? stc_pkg::SHIFT_MAX : sdy_q;
	end

	assign accept = start && !busy;
	assign in_range = (int'(in.col) < MAX_DIM) && (int'(in.row) < MAX_DIM);

	for (genvar l = 0; l < MAX_TEMPLATES; l++) begin : g_lane
		stc_lane #(
			.MAX_DIM  (MAX_DIM),
			.CHANNELS (CHANNELS)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr_en   (accept && in.op == stc_pkg::OP_TEMPLATE && in_range
				&& int'(in.slot) == l),
			.wr_addr ({AW'(in.row), AW'(in.col)}),
			.wr_data ({in.red, in.green, in.blue}),
			.rd_addr (tpl_addr),
			.pat_s1  (pat_s1),
			.ctl_s2  (ctl_s2),
			.best    (lane_best[l])
		);
	end

	stc_ctrl #(
		.MAX_TEMPLATES (MAX_TEMPLATES),
		.MAX_DIM       (MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in),
		.geom      (geom),
		.lane_best (lane_best),
		.tpl_addr  (tpl_addr),
		.pat_s1    (pat_s1),
		.ctl_s2    (ctl_s2),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

endmodule

[dv/stc_checker.sv]
// stc_checker: watches the item, result and register channels of the sad template
// classifier, predicts each classification and compares it with the result port
// depends on stc_pkg
module stc_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  stc_pkg::in_t  pix_in,
	input  logic          done,
	input  stc_pkg::out_t result,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [5:0]    cfg_data,
	output int            errors,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import stc_pkg::*;

	logic [23:0] tmpl_mem [16][32][32];
	logic [23:0] patch_mem [32][32];
	logic [5:0] r_tw, r_th, r_pw, r_ph;
	logic [4:0] r_cnt;
	logic [2:0] r_dx, r_dy;
	out_t class_q [$];

	initial errors = 0;
	assign pending = class_q.size();

	function automatic int clampi(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int byte_dist(input logic [23:0] a, input logic [23:0] b);
		int sum;
		int x;
		int y;
		sum = 0;
		for (int c = 0; c < 3; c++) begin
			x = a[8*c +: 8];
			y = b[8*c +: 8];
			sum += (x > y) ? x - y : y - x;
		end
		return sum;
	endfunction

	function automatic int template_sad(input int s, input int tw, input int th,
		input int pw, input int ph, input int sdx, input int sdy);
		int best;
		int sum;
		int bx;
		int by;
		best = -1;
		for (int dy = -sdy; dy <= sdy; dy++) begin
			for (int dx = -sdx; dx <= sdx; dx++) begin
				sum = 0;
				for (int y = 0; y < ph; y++) begin
					by = y + (th - pw*0 - ph) / 2 + dy;
					if (by < 0 || by >= th) continue;
					for (int x = 0; x < pw; x++) begin
						bx = x + (tw - pw) / 2 + dx;
						if (bx < 0 || bx >= tw) continue;
						sum += byte_dist(tmpl_mem[s][by][bx], patch_mem[y][x]);
						if (sum > int'(SCORE_MAX)) sum = int'(SCORE_MAX);
					end
				end
				if (best < 0 || sum < best) best = sum;
			end
		end
		return best;
	endfunction

	function automatic out_t classify();
		out_t o;
		int tw, th, pw, ph, cnt, sdx, sdy, s;
		tw = clampi(r_tw, 1, 32);
		th = clampi(r_th, 1, 32);
		pw = clampi(r_pw, 1, 32);
		ph = clampi(r_ph, 1, 32);
		cnt = clampi(r_cnt, 1, 16);
		sdx = clampi(r_dx, 0, 4);
		sdy = clampi(r_dy, 0, 4);
		o = '0;
		if (pw > tw || ph > th) begin
			o.best_score = SCORE_MAX;
			o.size_error = 1'b1;
		end else begin
			o.best_score = 20'(template_sad(0, tw, th, pw, ph, sdx, sdy));
			for (int t = 1; t < cnt; t++) begin
				s = template_sad(t, tw, th, pw, ph, sdx, sdy);
				if (s < int'(o.best_score)) begin
					o.best_score = 20'(s);
					o.best_template = 4'(t);
				end
			end
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t e;
		if (!arst_n) begin
			r_tw = TW_RST;
			r_th = TH_RST;
			r_pw = PW_RST;
			r_ph = PH_RST;
			r_cnt = CNT_RST;
			r_dx = SDX_RST;
			r_dy = SDY_RST;
			class_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TW: r_tw = cfg_data;
					REG_TH: r_th = cfg_data;
					REG_PW: r_pw = cfg_data;
					REG_PH: r_ph = cfg_data;
					REG_CNT: r_cnt = cfg_data[4:0];
					REG_SDX: r_dx = cfg_data[2:0];
					REG_SDY: r_dy = cfg_data[2:0];
					default: ;
				endcase
			end
			if (done) begin
				if (class_q.size() == 0) begin
					errors++;
					$display("%t unexpected result: expected none, actual %p", $realtime, result);
				end else begin
					e = class_q.pop_front();
					if (result.best_template !== e.best_template) begin
						errors++;
						$display("%t best_template: expected %0d, actual %0d", $realtime,
							e.best_template, result.best_template);
					end
					if (result.best_score !== e.best_score) begin
						errors++;
						$display("%t best_score: expected %0d, actual %0d", $realtime,
							e.best_score, result.best_score);
					end
					if (result.size_error !== e.size_error) begin
						errors++;
						$display("%t size_error: expected %0d, actual %0d", $realtime,
							e.size_error, result.size_error);
					end
				end
			end
			if (start && !busy) begin
				if (pix_in.op == OP_TEMPLATE) begin
					tmpl_mem[pix_in.slot][pix_in.row][pix_in.col] =
						{pix_in.red, pix_in.green, pix_in.blue};
				end else begin
					patch_mem[pix_in.row][pix_in.col] = {pix_in.red, pix_in.green, pix_in.blue};
					if (pix_in.last_pixel) class_q.push_back(classify());
				end
			end
		end
	end
endmodule

[dv/tb.sv]
// tb: top of the sad template classifier testbench; drives pixel loads, register
// writes and reset, and gives the verdict from the failure and pending counts of stc_checker
// depends on stc_pkg, stc_checker and the classifier rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import stc_pkg::*;

	localparam int STALL_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_t pix_in = '0;
	logic done;
	out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;
	int errors;
	int pending;
	int stall_cnt = 0;
	int idle_pct = 16;
	int g_tw, g_th, g_pw, g_ph, g_cnt;
	bit tmpl_written [16][32][32];
	bit patch_written [32][32];

	always #4 clk = ~clk;

	sad_template_classifier u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in(pix_in),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	stc_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pix_in(pix_in),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	function automatic int clampi(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [7:0] rnd_byte();
		int k;
		k = $urandom_range(0, 9);
		return (k == 0) ? 8'd0 : ((k == 1) ? 8'd255 : 8'($urandom));
	endfunction

	function automatic in_t make_pixel(input logic op, input int s, input int c, input int r,
		input logic last);
		in_t p;
		p.op = op;
		p.slot = 4'(s);
		p.col = 5'(c);
		p.row = 5'(r);
		p.blue = rnd_byte();
		p.green = rnd_byte();
		p.red = rnd_byte();
		p.last_pixel = last;
		return p;
	endfunction

	task automatic send(input in_t p);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		if (p.op == OP_TEMPLATE) tmpl_written[p.slot][p.row][p.col] = 1'b1;
		else patch_written[p.row][p.col] = 1'b1;
		start <= 1'b1;
		pix_in <= p;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 6'(v);
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_geom(input int tw, input int th, input int pw, input int ph,
		input int cnt, input int dx, input int dy);
		drain();
		write_reg(REG_TW, tw);
		write_reg(REG_TH, th);
		write_reg(REG_PW, pw);
		write_reg(REG_PH, ph);
		write_reg(REG_CNT, cnt);
		write_reg(REG_SDX, dx);
		write_reg(REG_SDY, dy);
		cfg_valid <= 1'b0;
		@(posedge clk);
		g_tw = clampi(tw, 1, 32);
		g_th = clampi(th, 1, 32);
		g_pw = clampi(pw, 1, 32);
		g_ph = clampi(ph, 1, 32);
		g_cnt = clampi(cnt % 32, 1, 16);
	endtask

	// load every pixel the next match reads, then the last patch pixel
	task automatic classify(input in_t p);
		if (g_pw <= g_tw && g_ph <= g_th) begin
			for (int s = 0; s < g_cnt; s++)
				for (int r = 0; r < g_th; r++)
					for (int c = 0; c < g_tw; c++)
						if (!tmpl_written[s][r][c]) send(make_pixel(OP_TEMPLATE, s, c, r, 1'b0));
			for (int r = 0; r < g_ph; r++)
				for (int c = 0; c < g_pw; c++)
					if (!patch_written[r][c] && !(p.row == r && p.col == c))
						send(make_pixel(OP_PATCH, 0, c, r, 1'b0));
		end
		send(p);
	endtask

	task automatic random_item();
		in_t p;
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			p = make_pixel(OP_TEMPLATE, $urandom_range(0, g_cnt - 1), $urandom_range(0, g_tw - 1),
				$urandom_range(0, g_th - 1), 1'($urandom));
			send(p);
		end else if (k < 85) begin
			send(make_pixel(OP_PATCH, $urandom_range(0, 15), $urandom_range(0, g_pw - 1),
				$urandom_range(0, g_ph - 1), 1'b0));
		end else if (k < 93) begin
			classify(make_pixel(OP_PATCH, $urandom_range(0, 15), $urandom_range(0, g_pw - 1),
				$urandom_range(0, g_ph - 1), 1'b1));
		end else begin
			p = make_pixel(1'($urandom), $urandom_range(0, 15), $urandom_range(0, 31),
				$urandom_range(0, 31), 1'($urandom));
			if (p.op == OP_PATCH && p.last_pixel) classify(p);
			else send(p);
		end
	endtask

	initial begin
		int tw, th;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all templates, widest search
		set_geom(4, 4, 2, 2, 16, 4, 4);
		classify(make_pixel(OP_PATCH, 0, 1, 1, 1'b1));
		send(make_pixel(OP_TEMPLATE, 15, 31, 31, 1'b1));
		classify(make_pixel(OP_PATCH, 15, 0, 0, 1'b1));
		// patch larger than template
		set_geom(4, 4, 5, 4, 3, 1, 1);
		classify(make_pixel(OP_PATCH, 0, 31, 31, 1'b1));
		set_geom(4, 4, 4, 5, 3, 1, 1);
		classify(make_pixel(OP_PATCH, 0, 0, 0, 1'b1));
		// register values outside their ranges saturate
		set_geom(0, 63, 0, 63, 0, 7, 7);
		classify(make_pixel(OP_PATCH, 0, 0, 5, 1'b1));
		set_geom(2, 2, 1, 1, 31, 7, 0);
		classify(make_pixel(OP_PATCH, 0, 0, 0, 1'b1));
		// patch as large as the template, no search
		set_geom(8, 8, 8, 8, 1, 0, 0);
		classify(make_pixel(OP_PATCH, 0, 7, 7, 1'b1));

		for (int ph = 0; ph < 9; ph++) begin
			tw = $urandom_range(1, 6);
			th = $urandom_range(1, 6);
			set_geom(tw, th,
				($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : $urandom_range(1, tw),
				($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : $urandom_range(1, th),
				$urandom_range(1, 16), $urandom_range(0, 4), $urandom_range(0, 4));
			idle_pct = (ph < 3) ? 16 : ((ph < 6) ? 58 : 0);
			repeat (30) random_item();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
